// ===== rtl/sem_pkg.sv =====
package sem_pkg;

    localparam int ERR_W = 32;
    localparam int ROW_W = 60;
    localparam int ENTRY_W = 20;
    localparam int COORD_W = 16;
    localparam int TOTAL_W = 42;
    localparam int COUNT_OUT_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_E_ROW_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_E_ROW_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_E_ROW_TWO = 2'd2;

    localparam logic [ERR_W-1:0] ERR_SAT = 32'hFFFF_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic             sat;
        logic             last;
    } item_t;

endpackage

// ===== rtl/sem_ram.sv =====
module sem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sem_fifo.sv =====
module sem_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  sem_pkg::item_t wdata,
    output logic          full,
    input  logic          rd,
    output sem_pkg::item_t rdata,
    output logic          empty
);

    sem_pkg::item_t slot_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic do_wr, do_rd;

    assign full = (cnt_reg == 3'd4);
    assign empty = (cnt_reg == 3'd0);
    assign rdata = slot_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wp_next = do_wr ? wp_reg + 2'd1 : wp_reg;
        rp_next = do_rd ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'b0, do_wr} - {2'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/sem_front.sv =====
module sem_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sem_pkg::ROW_W-1:0]          cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [sem_pkg::COORD_W-1:0] first_x,
    input  logic signed [sem_pkg::COORD_W-1:0] first_y,
    input  logic signed [sem_pkg::COORD_W-1:0] second_x,
    input  logic signed [sem_pkg::COORD_W-1:0] second_y,
    input  logic                               last_point,
    output logic                               q_wr,
    output sem_pkg::item_t                     q_data,
    input  logic                               q_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_CHK  = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [sem_pkg::ROW_W-1:0] row_reg [3];
    logic signed [sem_pkg::COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic last_reg;
    logic [4:0] cnt_reg;
    logic signed [37:0] ex_reg [3];
    logic signed [37:0] etx_reg [2];
    logic signed [54:0] alg_reg;
    logic [56:0] num_reg;
    logic [50:0] den_reg;
    logic signed [66:0] prod_reg;
    logic [50:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] quo_reg;
    logic sat_reg;

    logic signed [sem_pkg::ENTRY_W-1:0] e [3][3];
    logic signed [37:0] a_w;
    logic signed [28:0] b_w;
    logic signed [66:0] prod_w;
    logic signed [54:0] t_alg_full;
    logic signed [28:0] t_alg;
    logic signed [37:0] t_ex0_full, t_ex1_full, t_etx0_full, t_etx1_full;
    logic signed [24:0] t_ex0, t_ex1, t_etx0, t_etx1;
    logic [51:0] rem_shift;
    logic [51:0] den_ext;
    logic rem_ge;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e[r][c] = row_reg[r][20*c +: 20];
            end
        end
    end

    assign t_alg_full = alg_reg >>> 26;
    assign t_alg = t_alg_full[28:0];
    assign t_ex0_full = ex_reg[0] >>> 13;
    assign t_ex1_full = ex_reg[1] >>> 13;
    assign t_etx0_full = etx_reg[0] >>> 13;
    assign t_etx1_full = etx_reg[1] >>> 13;
    assign t_ex0 = t_ex0_full[24:0];
    assign t_ex1 = t_ex1_full[24:0];
    assign t_etx0 = t_etx0_full[24:0];
    assign t_etx1 = t_etx1_full[24:0];

    always_comb
    begin
        a_w = '0;
        b_w = '0;
        case (cnt_reg)
            5'd0:
            begin
                a_w = 38'(e[0][0]);
                b_w = 29'(x1_reg);
            end
            5'd1:
            begin
                a_w = 38'(e[0][1]);
                b_w = 29'(y1_reg);
            end
            5'd2:
            begin
                a_w = 38'(e[1][0]);
                b_w = 29'(x1_reg);
            end
            5'd3:
            begin
                a_w = 38'(e[1][1]);
                b_w = 29'(y1_reg);
            end
            5'd4:
            begin
                a_w = 38'(e[2][0]);
                b_w = 29'(x1_reg);
            end
            5'd5:
            begin
                a_w = 38'(e[2][1]);
                b_w = 29'(y1_reg);
            end
            5'd6:
            begin
                a_w = 38'(e[0][0]);
                b_w = 29'(x2_reg);
            end
            5'd7:
            begin
                a_w = 38'(e[1][0]);
                b_w = 29'(y2_reg);
            end
            5'd8:
            begin
                a_w = 38'(e[0][1]);
                b_w = 29'(x2_reg);
            end
            5'd9:
            begin
                a_w = 38'(e[1][1]);
                b_w = 29'(y2_reg);
            end
            5'd10:
            begin
                a_w = ex_reg[0];
                b_w = 29'(x2_reg);
            end
            5'd11:
            begin
                a_w = ex_reg[1];
                b_w = 29'(y2_reg);
            end
            5'd12:
            begin
                a_w = 38'(t_ex0);
                b_w = 29'(t_ex0);
            end
            5'd13:
            begin
                a_w = 38'(t_ex1);
                b_w = 29'(t_ex1);
            end
            5'd14:
            begin
                a_w = 38'(t_etx0);
                b_w = 29'(t_etx0);
            end
            5'd15:
            begin
                a_w = 38'(t_etx1);
                b_w = 29'(t_etx1);
            end
            5'd16:
            begin
                a_w = 38'(t_alg);
                b_w = t_alg;
            end
            default:
            begin
                a_w = '0;
                b_w = '0;
            end
        endcase
    end

    assign prod_w = a_w * b_w;

    assign rem_shift = {rem_reg, low_reg[31]};
    assign den_ext = {1'b0, den_reg};
    assign rem_ge = (rem_shift >= den_ext);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (cnt_reg == 5'd17)
                begin
                    state_next = F_CHK;
                end
            end
            F_CHK:
            begin
                if (den_reg == '0 || {2'b0, num_reg} >= {den_reg, 8'b0})
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg <= '0;
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    sem_pkg::REG_E_ROW_ZERO: row_reg[0] <= cfg_data;
                    sem_pkg::REG_E_ROW_ONE:  row_reg[1] <= cfg_data;
                    sem_pkg::REG_E_ROW_TWO:  row_reg[2] <= cfg_data;
                    default:                 row_reg[0] <= row_reg[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            x1_reg <= first_x;
            y1_reg <= first_y;
            x2_reg <= second_x;
            y2_reg <= second_y;
            last_reg <= last_point;
            for (int r = 0; r < 3; r++)
            begin
                ex_reg[r] <= 38'(e[r][2]) <<< 13;
            end
            for (int c = 0; c < 2; c++)
            begin
                etx_reg[c] <= 38'(e[2][c]) <<< 13;
            end
            den_reg <= '0;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= prod_w;
            case (cnt_reg)
                5'd1, 5'd2:   ex_reg[0] <= ex_reg[0] + prod_reg[37:0];
                5'd3, 5'd4:   ex_reg[1] <= ex_reg[1] + prod_reg[37:0];
                5'd5, 5'd6:   ex_reg[2] <= ex_reg[2] + prod_reg[37:0];
                5'd7, 5'd8:   etx_reg[0] <= etx_reg[0] + prod_reg[37:0];
                5'd9, 5'd10:  etx_reg[1] <= etx_reg[1] + prod_reg[37:0];
                5'd11:        alg_reg <= (55'(ex_reg[2]) <<< 13) + prod_reg[54:0];
                5'd12:        alg_reg <= alg_reg + prod_reg[54:0];
                5'd13, 5'd14, 5'd15, 5'd16:
                              den_reg <= den_reg + prod_reg[50:0];
                5'd17:        num_reg <= prod_reg[56:0];
                default:      ;
            endcase
        end
        if (state_reg == F_CHK)
        begin
            sat_reg <= (den_reg == '0 || {2'b0, num_reg} >= {den_reg, 8'b0});
            quo_reg <= sem_pkg::ERR_SAT;
            rem_reg <= {2'b0, num_reg[56:8]};
            low_reg <= {num_reg[7:0], 24'b0};
        end
        if (state_reg == F_DIV)
        begin
            low_reg <= {low_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], rem_ge};
            rem_reg <= rem_ge ? 51'(rem_shift - den_ext) : rem_shift[50:0];
        end
    end

    assign full = (state_reg != F_IDLE);
    assign q_wr = (state_reg == F_PUSH);
    assign q_data = '{err: quo_reg, sat: sat_reg, last: last_reg};

endmodule

// ===== rtl/sem_back.sv =====
module sem_back #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sem_pkg::item_t                       q_data,
    input  logic                                 q_empty,
    output logic                                 q_rd,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [sem_pkg::ERR_W-1:0]            median_error,
    output logic [sem_pkg::ERR_W-1:0]            mean_error,
    output logic [sem_pkg::COUNT_OUT_W-1:0]      point_count,
    output logic                                 saturated,
    output logic                                 overflowed
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_POINTS);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_ISSUE = 7'b0000010,
        B_LOAD  = 7'b0000100,
        B_SCAN  = 7'b0001000,
        B_TAIL  = 7'b0010000,
        B_CHECK = 7'b0100000,
        B_MEAN  = 7'b1000000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [sem_pkg::TOTAL_W-1:0] total_reg;
    logic sat_reg, cap_reg;
    logic [AW-1:0] i_reg, j_reg;
    logic rv_reg;
    logic [sem_pkg::ERR_W-1:0] cand_reg;
    logic [CW-1:0] less_reg, eq_reg;
    logic [sem_pkg::ERR_W-1:0] med_reg;
    logic [CW-1:0] rem_reg;
    logic [sem_pkg::TOTAL_W-1:0] qsh_reg;
    logic [5:0] mcnt_reg;
    logic out_valid_reg;
    logic done_wait_reg;
    logic [sem_pkg::ERR_W-1:0] out_med_reg, out_mean_reg;
    logic [CW-1:0] out_cnt_reg;
    logic out_sat_reg, out_cap_reg;

    logic [AW-1:0] raddr;
    logic [sem_pkg::ERR_W-1:0] rdata;
    logic ram_we;
    logic has_room;
    logic [sem_pkg::TOTAL_W:0] sum_w;
    logic [CW-1:0] k_w;
    logic [CW:0] hi_w;
    logic hit_w;
    logic [CW:0] rshift_w;
    logic rge_w;
    logic out_free;
    logic scan_end;

    assign has_room = (count_reg < MAX_C);
    assign q_rd = (state_reg == B_IDLE) && !done_wait_reg && !q_empty;
    assign ram_we = q_rd && has_room;
    assign sum_w = {1'b0, total_reg} + (sem_pkg::TOTAL_W + 1)'(q_data.err);
    assign k_w = count_reg >> 1;
    assign hi_w = {1'b0, less_reg} + {1'b0, eq_reg};
    assign hit_w = (less_reg <= k_w) && ({1'b0, k_w} < hi_w);
    assign rshift_w = {rem_reg, qsh_reg[sem_pkg::TOTAL_W-1]};
    assign rge_w = (rshift_w >= {1'b0, count_reg});
    assign out_free = !out_valid_reg || pop;
    assign scan_end = (CW'(j_reg) == count_reg - CW'(1));

    always_comb
    begin
        raddr = i_reg;
        if (state_reg == B_SCAN)
        begin
            raddr = j_reg;
        end
    end

    sem_ram #(
        .WIDTH(sem_pkg::ERR_W),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (q_data.err),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_rd && q_data.last)
                begin
                    state_next = B_ISSUE;
                end
            end
            B_ISSUE: state_next = B_LOAD;
            B_LOAD:  state_next = B_SCAN;
            B_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = B_TAIL;
                end
            end
            B_TAIL:  state_next = B_CHECK;
            B_CHECK:
            begin
                state_next = hit_w ? B_MEAN : B_ISSUE;
            end
            B_MEAN:
            begin
                if (mcnt_reg == 6'(sem_pkg::TOTAL_W - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            sat_reg <= 1'b0;
            cap_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            done_wait_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            rv_reg <= 1'b0;
            mcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && !(done_wait_reg && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_MEAN && state_next == B_IDLE)
            begin
                done_wait_reg <= 1'b1;
            end
            if (done_wait_reg && out_free)
            begin
                done_wait_reg <= 1'b0;
                out_valid_reg <= 1'b1;
                count_reg <= '0;
                total_reg <= '0;
                sat_reg <= 1'b0;
                cap_reg <= 1'b0;
            end
            if (q_rd)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CW'(1);
                    total_reg <= sum_w[sem_pkg::TOTAL_W] ? sem_pkg::TOTAL_MAX
                                                         : sum_w[sem_pkg::TOTAL_W-1:0];
                    sat_reg <= sat_reg | q_data.sat;
                end
                else
                begin
                    cap_reg <= 1'b1;
                end
                i_reg <= '0;
            end
            case (state_reg)
                B_LOAD:
                begin
                    j_reg <= '0;
                    rv_reg <= 1'b0;
                end
                B_SCAN:
                begin
                    j_reg <= j_reg + AW'(1);
                    rv_reg <= 1'b1;
                end
                B_CHECK:
                begin
                    i_reg <= i_reg + AW'(1);
                    mcnt_reg <= '0;
                end
                B_MEAN:
                begin
                    mcnt_reg <= mcnt_reg + 6'd1;
                end
                default:
                begin
                    rv_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_LOAD)
        begin
            cand_reg <= rdata;
            less_reg <= '0;
            eq_reg <= '0;
        end
        if ((state_reg == B_SCAN && rv_reg) || state_reg == B_TAIL)
        begin
            if (rdata < cand_reg)
            begin
                less_reg <= less_reg + CW'(1);
            end
            else if (rdata == cand_reg)
            begin
                eq_reg <= eq_reg + CW'(1);
            end
        end
        if (state_reg == B_CHECK)
        begin
            med_reg <= cand_reg;
            rem_reg <= '0;
            qsh_reg <= total_reg;
        end
        if (state_reg == B_MEAN)
        begin
            rem_reg <= rge_w ? CW'(rshift_w - {1'b0, count_reg}) : rshift_w[CW-1:0];
            qsh_reg <= {qsh_reg[sem_pkg::TOTAL_W-2:0], rge_w};
        end
        if (done_wait_reg && out_free)
        begin
            out_med_reg <= med_reg;
            out_mean_reg <= (|qsh_reg[sem_pkg::TOTAL_W-1:sem_pkg::ERR_W]) ? sem_pkg::ERR_SAT
                                                                      : qsh_reg[sem_pkg::ERR_W-1:0];
            out_cnt_reg <= count_reg;
            out_sat_reg <= sat_reg;
            out_cap_reg <= cap_reg;
        end
    end

    assign empty = !out_valid_reg;
    assign median_error = out_med_reg;
    assign mean_error = out_mean_reg;
    assign point_count = sem_pkg::COUNT_OUT_W'(out_cnt_reg);
    assign saturated = out_sat_reg;
    assign overflowed = out_cap_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("stored count beyond capacity");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg)
        else $error("result dropped without pop");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_SCAN |-> CW'(j_reg) < count_reg)
        else $error("scan address beyond stored count");

    a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != B_IDLE |-> !q_rd)
        else $error("queue read during selection");

endmodule

// ===== rtl/sampson_error_median_mean.sv =====
// Sampson error scoring of an essential matrix over a set of correspondences.
// Load the three matrix rows through cfg_we, cfg_index and cfg_data while the
// block is idle; they are kept across sets. Push one correspondence per item;
// last_point closes the set. The block raises full while a point is scored.
// A point passes through the scoring unit in steps: a shared multiplier, one
// check and a one-bit-per-cycle divider; a saturated error skips the divider.
// Scored errors pass through a four-entry queue to the set logic, which stores
// each in the error store while room remains. After the last point, the median
// is found by ranking candidates against the store through the single read
// port, followed by a mean division. The result then sits on the output ports
// while empty is low until popped; a stalled receiver holds the next set's
// result back and stops intake, so scoring stalls once the queue fills.
// Reset clears the set state, the queue and the matrix rows; the error store
// has no reset and needs no clearing pass.
module sampson_error_median_mean #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sem_pkg::ROW_W-1:0]          cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [sem_pkg::COORD_W-1:0] first_x,
    input  logic signed [sem_pkg::COORD_W-1:0] first_y,
    input  logic signed [sem_pkg::COORD_W-1:0] second_x,
    input  logic signed [sem_pkg::COORD_W-1:0] second_y,
    input  logic                               last_point,
    output logic                               empty,
    input  logic                               pop,
    output logic [sem_pkg::ERR_W-1:0]          median_error,
    output logic [sem_pkg::ERR_W-1:0]          mean_error,
    output logic [sem_pkg::COUNT_OUT_W-1:0]    point_count,
    output logic                               saturated,
    output logic                               overflowed
);

    sem_pkg::item_t f_data, b_data;
    logic f_wr, f_full, b_rd, b_empty;

    sem_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .last_point (last_point),
        .q_wr       (f_wr),
        .q_data     (f_data),
        .q_full     (f_full)
    );

    sem_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (f_wr),
        .wdata (f_data),
        .full  (f_full),
        .rd    (b_rd),
        .rdata (b_data),
        .empty (b_empty)
    );

    sem_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (b_data),
        .q_empty      (b_empty),
        .q_rd         (b_rd),
        .empty        (empty),
        .pop          (pop),
        .median_error (median_error),
        .mean_error   (mean_error),
        .point_count  (point_count),
        .saturated    (saturated),
        .overflowed   (overflowed)
    );

endmodule
